// ===== src/slx_pkg.sv =====
// shared types, constants and character codes for the command line lexer
package slx_pkg;

  localparam int unsigned MaxLineBytes = 65536;
  localparam int unsigned PosLimit = (MaxLineBytes < 65536) ? MaxLineBytes : 65536;
  localparam int unsigned PosW = $clog2(PosLimit + 1);
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ModeIdle,
    ModeWord,
    ModeSq,
    ModeDq
  } mode_e;

  typedef enum logic [2:0] {
    PendNone,
    PendBar,
    PendAmp,
    PendLt,
    PendGt
  } pend_e;

  typedef enum logic [2:0] {
    KindByte,
    KindWordEnd,
    KindOp,
    KindErr,
    KindDone
  } kind_e;

  localparam logic [3:0] TokWord    = 4'd0;
  localparam logic [3:0] TokOr      = 4'd1;
  localparam logic [3:0] TokPipe    = 4'd2;
  localparam logic [3:0] TokAnd     = 4'd3;
  localparam logic [3:0] TokSeq     = 4'd4;
  localparam logic [3:0] TokHeredoc = 4'd5;
  localparam logic [3:0] TokIn      = 4'd6;
  localparam logic [3:0] TokAppend  = 4'd7;
  localparam logic [3:0] TokOut     = 4'd8;

  localparam logic [1:0] ErrUnclosed = 2'd0;
  localparam logic [1:0] ErrAmp      = 2'd1;
  localparam logic [1:0] ErrTooLong  = 2'd2;

  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChMark = 8'h01;
  localparam logic [7:0] ChBar  = 8'h7C;
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChSq   = 8'h27;
  localparam logic [7:0] ChDq   = 8'h22;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChVt   = 8'h0B;
  localparam logic [7:0] ChFf   = 8'h0C;
  localparam logic [7:0] ChCr   = 8'h0D;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  word_byte;
    logic [3:0]  token_kind;
    logic        had_quotes;
    logic [15:0] start_pos;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    mode_e          mode;
    pend_e          pend;
    logic           quoted;
    logic [15:0]    tok_start;
    logic [PosW-1:0] pos;
    logic           failed;
  } lex_state_t;

  localparam lex_state_t StateReset = '{
    mode: ModeIdle, pend: PendNone, quoted: 1'b0,
    tok_start: 16'd0, pos: '0, failed: 1'b0
  };

  function automatic result_t mk_result(kind_e k, logic [7:0] wb, logic [3:0] tk,
                                        logic hq, logic [15:0] sp, logic [1:0] ec);
    result_t r;
    r.kind       = k;
    r.word_byte  = wb;
    r.token_kind = tk;
    r.had_quotes = hq;
    r.start_pos  = sp;
    r.error_code = ec;
    return r;
  endfunction

endpackage

// ===== src/slx_step.sv =====
// lexer step: next state and up to four results for one byte
module slx_step (
  input  slx_pkg::lex_state_t                        state_i,
  input  logic [7:0]                                 char_i,
  input  logic                                       line_end_i,
  output slx_pkg::lex_state_t                        state_o,
  output slx_pkg::result_t [slx_pkg::MaxResults-1:0] results_o,
  output logic [slx_pkg::CntW-1:0]                   count_o
);
  import slx_pkg::*;

  lex_state_t st;
  result_t [MaxResults-1:0] res;
  logic [CntW-1:0] n;
  logic [15:0] pos16;
  logic ends, skip, is_sp, is_op;
  pend_e p;

  always_comb begin
    st    = state_i;
    res   = '0;
    n     = '0;
    pos16 = 16'd0;
    skip  = 1'b0;
    p     = PendNone;
    ends  = line_end_i || (char_i == ChNul);
    is_sp = (char_i == ChSp) || (char_i == ChTab) || (char_i == ChLf) ||
            (char_i == ChCr) || (char_i == ChVt) || (char_i == ChFf);
    is_op = (char_i == ChBar) || (char_i == ChAmp) || (char_i == ChLt) ||
            (char_i == ChGt) || (char_i == ChSemi);

    if (char_i != ChNul && !st.failed) begin
      if (st.pos >= PosW'(PosLimit)) begin
        res[n[1:0]] = mk_result(KindErr, 8'd0, TokWord, 1'b0, 16'd0, ErrTooLong);
        n = n + 1'b1;
        st.failed = 1'b1;
      end else begin
        pos16  = 16'(st.pos);
        st.pos = st.pos + 1'b1;
        // lookahead on a pending operator
        if (st.pend != PendNone) begin
          if (st.pend == PendBar && char_i == ChBar) begin
            res[n[1:0]] = mk_result(KindOp, 8'd0, TokOr, 1'b0, st.tok_start, 2'd0);
            n = n + 1'b1;
            st.pend = PendNone;
            skip = 1'b1;
          end else if (st.pend == PendAmp && char_i == ChAmp) begin
            res[n[1:0]] = mk_result(KindOp, 8'd0, TokAnd, 1'b0, st.tok_start, 2'd0);
            n = n + 1'b1;
            st.pend = PendNone;
            skip = 1'b1;
          end else if (st.pend == PendLt && char_i == ChLt) begin
            res[n[1:0]] = mk_result(KindOp, 8'd0, TokHeredoc, 1'b0, st.tok_start, 2'd0);
            n = n + 1'b1;
            st.pend = PendNone;
            skip = 1'b1;
          end else if (st.pend == PendGt && char_i == ChGt) begin
            res[n[1:0]] = mk_result(KindOp, 8'd0, TokAppend, 1'b0, st.tok_start, 2'd0);
            n = n + 1'b1;
            st.pend = PendNone;
            skip = 1'b1;
          end else begin
            p = st.pend;
            st.pend = PendNone;
            case (p)
              PendBar: begin
                res[n[1:0]] = mk_result(KindOp, 8'd0, TokPipe, 1'b0, st.tok_start, 2'd0);
                n = n + 1'b1;
              end
              PendAmp: begin
                res[n[1:0]] = mk_result(KindErr, 8'd0, TokWord, 1'b0, 16'd0, ErrAmp);
                n = n + 1'b1;
                st.failed = 1'b1;
                skip = 1'b1;
              end
              PendLt: begin
                res[n[1:0]] = mk_result(KindOp, 8'd0, TokIn, 1'b0, st.tok_start, 2'd0);
                n = n + 1'b1;
              end
              PendGt: begin
                res[n[1:0]] = mk_result(KindOp, 8'd0, TokOut, 1'b0, st.tok_start, 2'd0);
                n = n + 1'b1;
              end
              default: ;
            endcase
          end
        end
        if (!skip) begin
          if (st.mode == ModeSq) begin
            if (char_i == ChSq) begin
              st.mode = ModeWord;
            end else begin
              res[n[1:0]] = mk_result(KindByte, ChMark, TokWord, 1'b0, 16'd0, 2'd0);
              n = n + 1'b1;
              res[n[1:0]] = mk_result(KindByte, char_i, TokWord, 1'b0, 16'd0, 2'd0);
              n = n + 1'b1;
            end
          end else if (st.mode == ModeDq) begin
            if (char_i == ChDq) begin
              st.mode = ModeWord;
            end else begin
              res[n[1:0]] = mk_result(KindByte, char_i, TokWord, 1'b0, 16'd0, 2'd0);
              n = n + 1'b1;
            end
          end else begin
            if (st.mode == ModeWord && (is_sp || is_op)) begin
              res[n[1:0]] = mk_result(KindWordEnd, 8'd0, TokWord, st.quoted,
                                      st.tok_start, 2'd0);
              n = n + 1'b1;
              st.mode   = ModeIdle;
              st.quoted = 1'b0;
            end
            if (is_sp) begin
              st.mode = st.mode;
            end else if (is_op) begin
              if (char_i == ChSemi) begin
                res[n[1:0]] = mk_result(KindOp, 8'd0, TokSeq, 1'b0, pos16, 2'd0);
                n = n + 1'b1;
              end else begin
                st.tok_start = pos16;
                if (char_i == ChBar) st.pend = PendBar;
                else if (char_i == ChAmp) st.pend = PendAmp;
                else if (char_i == ChLt) st.pend = PendLt;
                else st.pend = PendGt;
              end
            end else begin
              if (st.mode == ModeIdle) begin
                st.tok_start = pos16;
                st.quoted    = 1'b0;
                st.mode      = ModeWord;
              end
              if (char_i == ChSq) begin
                st.quoted = 1'b1;
                st.mode   = ModeSq;
              end else if (char_i == ChDq) begin
                st.quoted = 1'b1;
                st.mode   = ModeDq;
              end else begin
                res[n[1:0]] = mk_result(KindByte, char_i, TokWord, 1'b0, 16'd0, 2'd0);
                n = n + 1'b1;
              end
            end
          end
        end
      end
    end

    if (ends) begin
      if (!st.failed) begin
        if (st.pend != PendNone) begin
          p = st.pend;
          st.pend = PendNone;
          case (p)
            PendBar: begin
              res[n[1:0]] = mk_result(KindOp, 8'd0, TokPipe, 1'b0, st.tok_start, 2'd0);
              n = n + 1'b1;
            end
            PendAmp: begin
              res[n[1:0]] = mk_result(KindErr, 8'd0, TokWord, 1'b0, 16'd0, ErrAmp);
              n = n + 1'b1;
              st.failed = 1'b1;
            end
            PendLt: begin
              res[n[1:0]] = mk_result(KindOp, 8'd0, TokIn, 1'b0, st.tok_start, 2'd0);
              n = n + 1'b1;
            end
            PendGt: begin
              res[n[1:0]] = mk_result(KindOp, 8'd0, TokOut, 1'b0, st.tok_start, 2'd0);
              n = n + 1'b1;
            end
            default: ;
          endcase
        end
        if (!st.failed) begin
          if (st.mode == ModeWord) begin
            res[n[1:0]] = mk_result(KindWordEnd, 8'd0, TokWord, st.quoted,
                                    st.tok_start, 2'd0);
            n = n + 1'b1;
          end else if (st.mode == ModeSq || st.mode == ModeDq) begin
            res[n[1:0]] = mk_result(KindErr, 8'd0, TokWord, 1'b0, 16'd0, ErrUnclosed);
            n = n + 1'b1;
          end
        end
      end
      res[n[1:0]] = mk_result(KindDone, 8'd0, TokWord, 1'b0, 16'd0, 2'd0);
      n = n + 1'b1;
      st = StateReset;
    end
  end

  assign state_o   = st;
  assign results_o = res;
  assign count_o   = n;

endmodule

// ===== src/slx_resbuf.sv =====
// result register bank that drains one item's results one beat at a time
module slx_resbuf (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  slx_pkg::result_t [slx_pkg::MaxResults-1:0] load_res_i,
  input  logic [slx_pkg::CntW-1:0]                   load_cnt_i,
  output logic                                       ready_o,
  output logic                                       valid_o,
  input  logic                                       stall_i,
  output slx_pkg::result_t                           head_o,
  output logic                                       last_o
);
  import slx_pkg::*;

  result_t [MaxResults-1:0] res_q, res_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign ready_o = (cnt_q == '0) || (cnt_q == CntW'(1) && !stall_i);
  assign head_o  = res_q[0];
  assign last_o  = (cnt_q == CntW'(1));

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (load_i) begin
      res_d = load_res_i;
      cnt_d = load_cnt_i;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== src/shell_command_line_lexer.sv =====
// top level of the streaming command line lexer
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+--------------------------------------------
//  in      | in_valid_i   | in_stall_o   | char_in_i, line_end_i
//  out     | out_valid_o  | out_stall_i  | kind_o, word_byte_o, token_kind_o,
//          |              |              | had_quotes_o, start_pos_o, error_code_o,
//          |              |              | last_of_run_o
//
// a byte sits in the input register, is lexed in one pass and its results
// (zero to four) load the result bank, which drains one beat per cycle while out_stall_i is low
// the result bank sets the pace at which input beats are taken
// the next byte is taken while the last result of the previous one is sent
// rst_ni clears lexer state, the input valid flag and the result bank count
// out_stall_i reaches in_stall_o combinationally through the bank ready
module shell_command_line_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        line_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  word_byte_o,
  output logic [3:0]  token_kind_o,
  output logic        had_quotes_o,
  output logic [15:0] start_pos_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);
  import slx_pkg::*;

  logic in_vld_q, in_vld_d;
  logic [7:0] char_q;
  logic end_q;
  lex_state_t state_q, state_d, step_state;
  result_t [MaxResults-1:0] step_res;
  logic [CntW-1:0] step_cnt;
  logic buf_ready, advance, accept;
  result_t head;

  assign advance    = in_vld_q && buf_ready;
  assign in_stall_o = in_vld_q && !buf_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign state_d    = advance ? step_state : state_q;

  slx_step u_step (
    .state_i    (state_q),
    .char_i     (char_q),
    .line_end_i (end_q),
    .state_o    (step_state),
    .results_o  (step_res),
    .count_o    (step_cnt)
  );

  slx_resbuf u_resbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .load_res_i (step_res),
    .load_cnt_i (step_cnt),
    .ready_o    (buf_ready),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .head_o     (head),
    .last_o     (last_of_run_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= StateReset;
    end else begin
      in_vld_q <= in_vld_d;
      state_q  <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_in_i;
      end_q  <= line_end_i;
    end
  end

  assign kind_o       = head.kind;
  assign word_byte_o  = head.word_byte;
  assign token_kind_o = head.token_kind;
  assign had_quotes_o = head.had_quotes;
  assign start_pos_o  = head.start_pos;
  assign error_code_o = head.error_code;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the command line lexer: directed and random lines checked beat by beat
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slx_pkg::*;

  typedef struct packed {
    result_t res;
    logic    last;
  } lex_beat_t;

  class lexer_scoreboard;
    mode_e           mode;
    pend_e           pend;
    logic            quoted;
    logic [15:0]     tok_start;
    logic [PosW-1:0] pos;
    logic            failed;
    lex_beat_t       step_out[$];
    lex_beat_t       token_queue[$];
    int              errors;
    int              checked;
    int              bytes_seen;
    int              lines_seen;
    int              lines_failed;

    function new();
      clear();
    endfunction

    function void clear();
      mode      = ModeIdle;
      pend      = PendNone;
      quoted    = 1'b0;
      tok_start = '0;
      pos       = '0;
      failed    = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == ChSp || c == ChTab || c == ChLf || c == ChCr || c == ChVt || c == ChFf;
    endfunction

    function bit is_op_char(logic [7:0] c);
      return c == ChBar || c == ChAmp || c == ChLt || c == ChGt || c == ChSemi;
    endfunction

    function void emit(kind_e k, logic [7:0] wb, logic [3:0] tk, logic hq, logic [15:0] sp,
                       logic [1:0] ec);
      lex_beat_t b;
      if (step_out.size() >= MaxResults) return;
      b.res.kind       = k;
      b.res.word_byte  = wb;
      b.res.token_kind = tk;
      b.res.had_quotes = hq;
      b.res.start_pos  = sp;
      b.res.error_code = ec;
      b.last           = 1'b0;
      step_out.push_back(b);
    endfunction

    function void raise_err(logic [1:0] ec);
      emit(KindErr, '0, '0, 1'b0, '0, ec);
      failed = 1'b1;
      lines_failed++;
    endfunction

    function void close_word();
      emit(KindWordEnd, '0, TokWord, quoted, tok_start, '0);
      mode   = ModeIdle;
      quoted = 1'b0;
    endfunction

    function logic [7:0] twin_char(pend_e p);
      case (p)
        PendBar: return ChBar;
        PendAmp: return ChAmp;
        PendLt:  return ChLt;
        default: return ChGt;
      endcase
    endfunction

    function logic [3:0] double_tok(pend_e p);
      case (p)
        PendBar: return TokOr;
        PendAmp: return TokAnd;
        PendLt:  return TokHeredoc;
        default: return TokAppend;
      endcase
    endfunction

    function void flush_pending();
      pend_e p;
      p    = pend;
      pend = PendNone;
      case (p)
        PendBar: emit(KindOp, '0, TokPipe, 1'b0, tok_start, '0);
        PendAmp: raise_err(ErrAmp);
        PendLt:  emit(KindOp, '0, TokIn, 1'b0, tok_start, '0);
        PendGt:  emit(KindOp, '0, TokOut, 1'b0, tok_start, '0);
        default: ;
      endcase
    endfunction

    function void lex_byte(logic [7:0] c, logic [15:0] at);
      if (pend != PendNone) begin
        if (c == twin_char(pend)) begin
          emit(KindOp, '0, double_tok(pend), 1'b0, tok_start, '0);
          pend = PendNone;
          return;
        end
        flush_pending();
        if (failed) return;
      end
      if (mode == ModeSq) begin
        if (c == ChSq) begin
          mode = ModeWord;
        end else begin
          emit(KindByte, ChMark, '0, 1'b0, '0, '0);
          emit(KindByte, c, '0, 1'b0, '0, '0);
        end
        return;
      end
      if (mode == ModeDq) begin
        if (c == ChDq) mode = ModeWord;
        else emit(KindByte, c, '0, 1'b0, '0, '0);
        return;
      end
      if (mode == ModeWord && (is_blank(c) || is_op_char(c))) close_word();
      if (is_blank(c)) return;
      if (is_op_char(c)) begin
        if (c == ChSemi) begin
          emit(KindOp, '0, TokSeq, 1'b0, at, '0);
        end else begin
          tok_start = at;
          pend = (c == ChBar) ? PendBar : (c == ChAmp) ? PendAmp : (c == ChLt) ? PendLt : PendGt;
        end
        return;
      end
      if (mode == ModeIdle) begin
        tok_start = at;
        quoted    = 1'b0;
        mode      = ModeWord;
      end
      if (c == ChSq) begin
        quoted = 1'b1;
        mode   = ModeSq;
      end else if (c == ChDq) begin
        quoted = 1'b1;
        mode   = ModeDq;
      end else begin
        emit(KindByte, c, '0, 1'b0, '0, '0);
      end
    endfunction

    function void note_byte(logic [7:0] c, logic le);
      logic        ends;
      logic [15:0] at;
      lex_beat_t   b;
      ends = le || (c == ChNul);
      step_out.delete();
      bytes_seen++;
      if (c != ChNul && !failed) begin
        if (32'(pos) >= PosLimit) begin
          raise_err(ErrTooLong);
        end else begin
          at = pos[15:0];
          pos++;
          lex_byte(c, at);
        end
      end
      if (ends) begin
        if (!failed && pend != PendNone) flush_pending();
        if (!failed) begin
          if (mode == ModeWord) close_word();
          else if (mode == ModeSq || mode == ModeDq) raise_err(ErrUnclosed);
        end
        emit(KindDone, '0, '0, 1'b0, '0, '0);
        clear();
        lines_seen++;
      end
      if (step_out.size() > 0) begin
        b = step_out.pop_back();
        b.last = 1'b1;
        step_out.push_back(b);
      end
      foreach (step_out[i]) token_queue.push_back(step_out[i]);
    endfunction

    function int outstanding();
      return token_queue.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h on result %0d", name, got, want, checked));
    endtask

    task check_token(result_t got, logic got_last);
      lex_beat_t want;
      if (token_queue.size() == 0) begin
        report($sformatf("result of kind %0d with nothing expected", got.kind));
        return;
      end
      want = token_queue.pop_front();
      checked++;
      compare_field("kind", 16'(got.kind), 16'(want.res.kind));
      compare_field("word_byte", 16'(got.word_byte), 16'(want.res.word_byte));
      compare_field("token_kind", 16'(got.token_kind), 16'(want.res.token_kind));
      compare_field("had_quotes", 16'(got.had_quotes), 16'(want.res.had_quotes));
      compare_field("start_pos", got.start_pos, want.res.start_pos);
      compare_field("error_code", 16'(got.error_code), 16'(want.res.error_code));
      compare_field("last_of_run", 16'(got_last), 16'(want.last));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i    = '0;
  logic        line_end_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  word_byte_o;
  logic [3:0]  token_kind_o;
  logic        had_quotes_o;
  logic [15:0] start_pos_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  lexer_scoreboard sb;
  int              items_sent = 0;
  bit              calm       = 1'b0;
  string           op_text[9] = '{"|", "||", "&", "&&", ";", "<", "<<", ">", ">>"};
  logic [7:0]      blank_set[6] = '{ChSp, ChTab, ChLf, ChVt, ChFf, ChCr};

  shell_command_line_lexer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 28);

  // result side: sample between edges, take the beat at the next edge
  initial begin
    logic    fire;
    logic    got_last;
    result_t got;
    forever begin
      @(negedge clk_i);
      fire     = rst_ni && out_valid_o && !out_stall_i;
      got      = {kind_o, word_byte_o, token_kind_o, had_quotes_o, start_pos_o, error_code_o};
      got_last = last_of_run_o;
      @(posedge clk_i);
      if (fire) sb.check_token(got, got_last);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic le);
    logic took;
    if (!calm && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 28);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    line_end_i <= le;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    sb.note_byte(c, le);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (sb.is_blank(c) || sb.is_op_char(c) || c == ChSq || c == ChDq);
    return c;
  endfunction

  task automatic send_random_line();
    logic [7:0] line_q[$];
    logic [7:0] q;
    logic [7:0] c;
    string      s;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: repeat ($urandom_range(1, 4)) line_q.push_back(word_char());
          4, 5: begin
            q = $urandom_range(1) ? ChSq : ChDq;
            line_q.push_back(q);
            repeat ($urandom_range(0, 3)) begin
              do c = 8'($urandom_range(1, 255)); while (c == q);
              line_q.push_back(c);
            end
            if ($urandom_range(9) != 0) line_q.push_back(q);
          end
          6, 7: begin
            s = op_text[$urandom_range(8)];
            for (int j = 0; j < s.len(); j++) line_q.push_back(s[j]);
          end
          default: repeat ($urandom_range(1, 2)) line_q.push_back(blank_set[$urandom_range(5)]);
        endcase
      end
    end
    if (line_q.size() != 0 && $urandom_range(99) < 70) begin
      foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
    end else begin
      foreach (line_q[i]) send_byte(line_q[i], 1'b0);
      send_byte(ChNul, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int base;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every operator, quoting styles, unclosed quote and lone ampersand errors, zero byte endings
    send_text("a||b&&;<<e>>", 1'b1);
    send_text("|x<", 1'b0);
    send_byte(ChTab, 1'b0);
    send_text(">'", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChMark, 1'b0);
    send_text("'\"\"", 1'b0);
    send_byte(ChNul, 1'b0);
    send_text("&x", 1'b1);
    send_text("\"a ;", 1'b1);
    send_text("''&", 1'b1);
    send_byte(ChNul, 1'b1);
    wait_drained();

    base = items_sent;
    while (items_sent - base < 375) begin
      calm = (items_sent - base >= 150) && (items_sent - base < 250);
      send_random_line();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d bytes in %0d lines, %0d result beats compared",
             sb.bytes_seen, sb.lines_seen, sb.checked);
    $display("%0d lines ended in an error", sb.lines_failed);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("timeout waiting for the lexer");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
